// ----- rtl/vrca_pkg.sv -----
package vrca_pkg;

   localparam int WIDE_W     = 48;
   localparam int STEP_W     = 33;
   localparam int SUM_W      = 28;
   localparam int DIMV_W     = 9;
   localparam int CNTX_W     = 11;
   localparam int OUT_SUM_W  = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int VAL_W      = 16;
   localparam int POS_W      = 32;
   localparam int IDX_IN_W   = 5;
   localparam int CFG_DIM_W  = 6;
   localparam int CFG_SC_W   = 9;
   localparam int CFG_SH_W   = 4;
   localparam int FRAC_W     = 16;

   localparam logic [CSR_IDX_W-1:0] REG_VOL_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VOL_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VOL_DEPTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_SHIFT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VOXEL    = 3'd5;

   localparam logic [CFG_DIM_W-1:0]    RST_DIM       = 6'd32;
   localparam logic [CFG_SC_W-1:0]     RST_SAMPLES   = 9'd128;
   localparam logic [CFG_SH_W-1:0]     RST_SHIFT     = 4'd7;
   localparam logic signed [VAL_W-1:0] RST_MAX_VOXEL = 16'sd32767;

   localparam logic signed [WIDE_W-1:0] FRAC_ONE = 48'sd65536;
   localparam logic signed [SUM_W-1:0]  SUM_MAX  = 28'sd8388607;
   localparam logic signed [SUM_W-1:0]  SUM_MIN  = -28'sd8388608;

   localparam logic NUM_ZERO = 1'b0;
   localparam logic NUM_LAST = 1'b1;

   typedef struct packed {
      logic       load;
      logic       wr_en;
      logic       div_start;
      logic       num_sel;
      logic [1:0] ax;
      logic       clip;
      logic       adv;
      logic [1:0] adv_ax;
      logic       emul;
      logic       set_len;
      logic       thr;
      logic       sample;
      logic       fin;
      logic       fin_hit;
   } dp_cmd_type;

   typedef struct packed {
      logic dims_ok;
      logic s_neg;
      logic s_high;
      logic st_pos;
      logic st_neg;
      logic e_high;
      logic e_low;
      logic div_done;
      logic delta_ok;
      logic q_neg;
      logic len_zero;
   } dp_stat_type;

   typedef struct packed {
      logic                      req_type;
      logic [IDX_IN_W-1:0]       voxel_x;
      logic [IDX_IN_W-1:0]       voxel_y;
      logic [IDX_IN_W-1:0]       voxel_z;
      logic signed [VAL_W-1:0]   voxel_value;
      logic signed [POS_W-1:0]   start_x;
      logic signed [POS_W-1:0]   start_y;
      logic signed [POS_W-1:0]   start_z;
      logic signed [POS_W-1:0]   end_x;
      logic signed [POS_W-1:0]   end_y;
      logic signed [POS_W-1:0]   end_z;
   } req_payload_type;

   typedef struct packed {
      logic                        ray_hit;
      logic signed [OUT_SUM_W-1:0] ray_sum;
      logic                        over_limit;
   } rsp_payload_type;

endpackage

// ----- rtl/vrca_if.sv -----
interface vrca_req_if import vrca_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    req_type;
   logic [IDX_IN_W-1:0]     voxel_x;
   logic [IDX_IN_W-1:0]     voxel_y;
   logic [IDX_IN_W-1:0]     voxel_z;
   logic signed [VAL_W-1:0] voxel_value;
   logic signed [POS_W-1:0] start_x;
   logic signed [POS_W-1:0] start_y;
   logic signed [POS_W-1:0] start_z;
   logic signed [POS_W-1:0] end_x;
   logic signed [POS_W-1:0] end_y;
   logic signed [POS_W-1:0] end_z;
   modport source (output valid, req_type, voxel_x, voxel_y, voxel_z, voxel_value,
                   start_x, start_y, start_z, end_x, end_y, end_z, input ready);
   modport sink (input valid, req_type, voxel_x, voxel_y, voxel_z, voxel_value,
                 start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

interface vrca_rsp_if import vrca_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        ray_hit;
   logic signed [OUT_SUM_W-1:0] ray_sum;
   logic                        over_limit;
   modport source (output valid, ray_hit, ray_sum, over_limit, input ready);
   modport sink (input valid, ray_hit, ray_sum, over_limit, output ready);
endinterface

interface vrca_csr_if import vrca_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/vrca_ram.sv -----
module vrca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/vrca_div.sv -----
module vrca_div import vrca_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WIDE_W-1:0] num,
   input  logic signed [STEP_W-1:0] den,
   output logic                     done,
   output logic signed [WIDE_W-1:0] quot
);

   localparam int ITER_W = $clog2(WIDE_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [WIDE_W-1:0] nq_ff, nq_in;
   logic [STEP_W:0]   rem_ff, rem_in;
   logic [STEP_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [STEP_W:0]   rem_sh;
   logic [STEP_W:0]   rem_sub;

   assign rem_sh  = {rem_ff[STEP_W-1:0], nq_ff[WIDE_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         nq_in   = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
         den_in  = den[STEP_W-1] ? STEP_W'(-den) : STEP_W'(den);
         rem_in  = '0;
         neg_in  = num[WIDE_W-1] ^ den[STEP_W-1];
      end else if (busy_ff) begin
         if (!rem_sub[STEP_W]) begin
            rem_in = rem_sub;
            nq_in  = {nq_ff[WIDE_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            nq_in  = {nq_ff[WIDE_W-2:0], 1'b0};
         end
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(WIDE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(nq_ff) : $signed(nq_ff);

endmodule

// ----- rtl/vrca_dp.sv -----
module vrca_dp import vrca_pkg::*; #(
   parameter int DIM_MAX     = 32,
   parameter int MAX_SAMPLES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  req_payload_type       req_pl,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output rsp_payload_type       rsp_pl
);

   localparam int IDX_W  = $clog2(DIM_MAX);
   localparam int ADDR_W = 3 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int THR_W  = CNT_W + VAL_W + 1;

   logic [CFG_DIM_W-1:0]    vol_ff [3];
   logic [CFG_SC_W-1:0]     sc_ff;
   logic [CFG_SH_W-1:0]     shift_ff;
   logic signed [VAL_W-1:0] maxv_ff;

   logic signed [WIDE_W-1:0] pos_ff [3];
   logic signed [STEP_W-1:0] step_ff [3];
   logic [CNT_W-1:0]         len_ff;
   logic [CNT_W-1:0]         delta_ff;
   logic signed [WIDE_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  thr_ff;
   logic                     rd_pend_ff;
   rsp_payload_type          rsp_ff;

   logic [DIMV_W-1:0]        dim [3];
   logic [CNT_W-1:0]         cnt;
   logic signed [POS_W-1:0]  start_v [3];
   logic signed [POS_W-1:0]  end_v [3];
   logic signed [STEP_W-1:0] diff [3];
   logic signed [WIDE_W-1:0] s_v, e_v, top_v, last_v, num_v, st_w, q;
   logic signed [STEP_W-1:0] st;
   logic signed [WIDE_W:0]   len_new;
   logic signed [CNT_W+STEP_W:0] adv_prod, len_prod;
   logic signed [THR_W-1:0]  thr_prod, thr_adj;
   logic [2:0]               inb_ax;
   logic                     inb;
   logic                     wr_ok;
   logic [ADDR_W-1:0]        raddr, waddr;
   logic [VAL_W-1:0]         rdata;

   assign start_v = '{req_pl.start_x, req_pl.start_y, req_pl.start_z};
   assign end_v   = '{req_pl.end_x, req_pl.end_y, req_pl.end_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dim[i] = ({3'b0, vol_ff[i]} > DIMV_W'(DIM_MAX)) ? DIMV_W'(DIM_MAX)
                                                         : {3'b0, vol_ff[i]};
         diff[i] = STEP_W'(end_v[i]) - STEP_W'(start_v[i]);
         inb_ax[i] = !pos_ff[i][WIDE_W-1] &&
                     (pos_ff[i][WIDE_W-1:FRAC_W] < (WIDE_W-FRAC_W)'(dim[i]));
      end
   end

   assign cnt = (CNTX_W'(sc_ff) > CNTX_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                        : CNT_W'(sc_ff);

   assign s_v    = pos_ff[cmd.ax];
   assign st     = step_ff[cmd.ax];
   assign st_w   = WIDE_W'(st);
   assign top_v  = $signed({{(WIDE_W-DIMV_W-FRAC_W){1'b0}}, dim[cmd.ax], {FRAC_W{1'b0}}});
   assign last_v = top_v - FRAC_ONE;
   assign e_v    = s_v + prod_ff;
   assign num_v  = ((cmd.num_sel == NUM_LAST) ? last_v : '0) - s_v;

   vrca_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_v),
      .den   (st),
      .done  (stat.div_done),
      .quot  (q)
   );

   assign len_new  = $signed({{(WIDE_W+1-CNT_W){1'b0}}, len_ff}) - $signed({q[WIDE_W-1], q})
                     - $signed({{WIDE_W{1'b0}}, 1'b1});
   assign adv_prod = $signed({1'b0, delta_ff}) * step_ff[cmd.adv_ax];
   assign len_prod = $signed({1'b0, len_ff}) * st;
   assign thr_prod = $signed({1'b0, cnt}) * maxv_ff;
   assign thr_adj  = thr_prod + $signed({{(THR_W-1){1'b0}}, thr_prod[THR_W-1]});

   assign stat.dims_ok  = (dim[0] != '0) && (dim[1] != '0) && (dim[2] != '0);
   assign stat.s_neg    = s_v < 0;
   assign stat.s_high   = s_v >= top_v;
   assign stat.st_pos   = st_w > 0;
   assign stat.st_neg   = st_w < 0;
   assign stat.e_high   = e_v >= top_v;
   assign stat.e_low    = e_v < 0;
   assign stat.delta_ok = !len_new[WIDE_W];
   assign stat.q_neg    = q[WIDE_W-1];
   assign stat.len_zero = len_ff == '0;

   assign inb   = &inb_ax;
   assign raddr = {pos_ff[2][FRAC_W +: IDX_W], pos_ff[1][FRAC_W +: IDX_W],
                   pos_ff[0][FRAC_W +: IDX_W]};
   assign wr_ok = (int'(req_pl.voxel_x) < DIM_MAX) && (int'(req_pl.voxel_y) < DIM_MAX) &&
                  (int'(req_pl.voxel_z) < DIM_MAX);
   assign waddr = {IDX_W'(req_pl.voxel_z), IDX_W'(req_pl.voxel_y), IDX_W'(req_pl.voxel_x)};

   vrca_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (cmd.wr_en && wr_ok),
      .waddr (waddr),
      .wdata (req_pl.voxel_value),
      .re    (cmd.sample),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff     <= '{RST_DIM, RST_DIM, RST_DIM};
         sc_ff      <= RST_SAMPLES;
         shift_ff   <= RST_SHIFT;
         maxv_ff    <= RST_MAX_VOXEL;
         rd_pend_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_VOL_WIDTH:    vol_ff[0] <= csr_data[CFG_DIM_W-1:0];
               REG_VOL_HEIGHT:   vol_ff[1] <= csr_data[CFG_DIM_W-1:0];
               REG_VOL_DEPTH:    vol_ff[2] <= csr_data[CFG_DIM_W-1:0];
               REG_SAMPLE_COUNT: sc_ff     <= csr_data[CFG_SC_W-1:0];
               REG_STEP_SHIFT:   shift_ff  <= csr_data[CFG_SH_W-1:0];
               REG_MAX_VOXEL:    maxv_ff   <= $signed(csr_data[VAL_W-1:0]);
               default: begin
               end
            endcase
         end
         rd_pend_ff <= cmd.sample && inb;
      end

      if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]  <= WIDE_W'(start_v[i]);
            step_ff[i] <= diff[i] >>> shift_ff;
         end
         len_ff <= cnt;
         sum_ff <= '0;
      end
      if (cmd.clip) begin
         len_ff   <= len_new[CNT_W-1:0];
         delta_ff <= q[CNT_W-1:0] + CNT_W'(1);
      end
      if (cmd.adv) begin
         pos_ff[cmd.adv_ax] <= pos_ff[cmd.adv_ax] + WIDE_W'(adv_prod);
      end
      if (cmd.emul) begin
         prod_ff <= WIDE_W'(len_prod);
      end
      if (cmd.set_len) begin
         len_ff <= q[CNT_W-1:0];
      end
      if (cmd.thr) begin
         thr_ff <= SUM_W'(thr_adj >>> 1);
      end
      if (cmd.sample) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= pos_ff[i] + WIDE_W'(step_ff[i]);
         end
         len_ff <= len_ff - CNT_W'(1);
      end
      if (rd_pend_ff) begin
         sum_ff <= sum_ff + SUM_W'($signed(rdata));
      end
      if (cmd.fin) begin
         if (cmd.fin_hit) begin
            rsp_ff.ray_hit    <= 1'b1;
            rsp_ff.over_limit <= sum_ff > thr_ff;
            if (sum_ff > SUM_MAX) begin
               rsp_ff.ray_sum <= SUM_MAX[OUT_SUM_W-1:0];
            end else if (sum_ff < SUM_MIN) begin
               rsp_ff.ray_sum <= SUM_MIN[OUT_SUM_W-1:0];
            end else begin
               rsp_ff.ray_sum <= sum_ff[OUT_SUM_W-1:0];
            end
         end else begin
            rsp_ff <= '0;
         end
      end
   end

   assign rsp_pl = rsp_ff;

endmodule

// ----- rtl/vrca_ctrl.sv -----
module vrca_ctrl import vrca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_type,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_AXIS  = 4'd1;
   localparam logic [3:0] S_DIV1  = 4'd2;
   localparam logic [3:0] S_CLIP  = 4'd3;
   localparam logic [3:0] S_ADV   = 4'd4;
   localparam logic [3:0] S_EMUL  = 4'd5;
   localparam logic [3:0] S_ECHK  = 4'd6;
   localparam logic [3:0] S_DIV2  = 4'd7;
   localparam logic [3:0] S_SETL  = 4'd8;
   localparam logic [3:0] S_THR   = 4'd9;
   localparam logic [3:0] S_SAMP  = 4'd10;
   localparam logic [3:0] S_DRAIN = 4'd11;
   localparam logic [3:0] S_FIN   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [1:0] ax_ff, ax_in;
   logic [1:0] adv_ff, adv_in;
   logic       hit_ff, hit_in;
   logic       out_valid_ff, out_valid_in;

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      adv_in       = adv_ff;
      hit_in       = hit_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      cmd.ax       = ax_ff;
      cmd.adv_ax   = adv_ff;
      req_ready    = 1'b0;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load  = 1'b1;
               cmd.wr_en = !req_type;
               ax_in     = 2'd0;
               if (req_type && stat.dims_ok) begin
                  hit_in   = 1'b1;
                  state_in = S_AXIS;
               end else begin
                  hit_in   = 1'b0;
                  state_in = S_FIN;
               end
            end
         end
         S_AXIS: begin
            if (stat.s_neg) begin
               if (stat.st_pos) begin
                  cmd.div_start = 1'b1;
                  cmd.num_sel   = NUM_ZERO;
                  state_in      = S_DIV1;
               end else begin
                  hit_in   = 1'b0;
                  state_in = S_FIN;
               end
            end else if (stat.s_high) begin
               if (stat.st_neg) begin
                  cmd.div_start = 1'b1;
                  cmd.num_sel   = NUM_LAST;
                  state_in      = S_DIV1;
               end else begin
                  hit_in   = 1'b0;
                  state_in = S_FIN;
               end
            end else begin
               state_in = S_EMUL;
            end
         end
         S_DIV1: begin
            if (stat.div_done) begin
               state_in = S_CLIP;
            end
         end
         S_CLIP: begin
            if (stat.delta_ok) begin
               cmd.clip = 1'b1;
               adv_in   = 2'd0;
               state_in = S_ADV;
            end else begin
               hit_in   = 1'b0;
               state_in = S_FIN;
            end
         end
         S_ADV: begin
            cmd.adv = 1'b1;
            adv_in  = adv_ff + 2'd1;
            if (adv_ff == 2'd2) begin
               state_in = S_EMUL;
            end
         end
         S_EMUL: begin
            cmd.emul = 1'b1;
            state_in = S_ECHK;
         end
         S_ECHK: begin
            if (stat.e_high) begin
               if (stat.st_pos) begin
                  cmd.div_start = 1'b1;
                  cmd.num_sel   = NUM_LAST;
                  state_in      = S_DIV2;
               end else begin
                  hit_in   = 1'b0;
                  state_in = S_FIN;
               end
            end else if (stat.e_low) begin
               if (stat.st_neg) begin
                  cmd.div_start = 1'b1;
                  cmd.num_sel   = NUM_ZERO;
                  state_in      = S_DIV2;
               end else begin
                  hit_in   = 1'b0;
                  state_in = S_FIN;
               end
            end else if (ax_ff == 2'd2) begin
               state_in = S_THR;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_AXIS;
            end
         end
         S_DIV2: begin
            if (stat.div_done) begin
               state_in = S_SETL;
            end
         end
         S_SETL: begin
            if (stat.q_neg) begin
               hit_in   = 1'b0;
               state_in = S_FIN;
            end else begin
               cmd.set_len = 1'b1;
               if (ax_ff == 2'd2) begin
                  state_in = S_THR;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = S_AXIS;
               end
            end
         end
         S_THR: begin
            cmd.thr  = 1'b1;
            state_in = S_SAMP;
         end
         S_SAMP: begin
            if (stat.len_zero) begin
               state_in = S_DRAIN;
            end else begin
               cmd.sample = 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.fin      = 1'b1;
               cmd.fin_hit  = hit_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ax_ff        <= 2'd0;
         adv_ff       <= 2'd0;
         hit_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ax_ff        <= ax_in;
         adv_ff       <= adv_in;
         hit_ff       <= hit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ----- rtl/voxel_ray_clip_accumulate_core.sv -----
// channel  | dir | transfer moves
// req_if   | in  | voxel write or ray cast request
// rsp_if   | out | hit, saturated sum, over-limit flag
// csr_if   | in  | register index and write data
// a ray cast runs up to six serial divisions and one voxel ram read per sample
// synchronous reset clears control and loads csr register defaults; datapath registers and voxel ram are not cleared
// result sits in an output register; next request is taken while it waits
// csr writes always accepted
module voxel_ray_clip_accumulate_core import vrca_pkg::*; #(
   parameter int DIM_MAX     = 32,
   parameter int MAX_SAMPLES = 256
) (
   input logic        clock,
   input logic        reset,
   vrca_req_if.sink   req_if,
   vrca_rsp_if.source rsp_if,
   vrca_csr_if.sink   csr_if
);

   dp_cmd_type      cmd;
   dp_stat_type     stat;
   req_payload_type req_pl;
   rsp_payload_type rsp_pl;

   assign req_pl = '{req_type: req_if.req_type, voxel_x: req_if.voxel_x,
                     voxel_y: req_if.voxel_y, voxel_z: req_if.voxel_z,
                     voxel_value: req_if.voxel_value, start_x: req_if.start_x,
                     start_y: req_if.start_y, start_z: req_if.start_z,
                     end_x: req_if.end_x, end_y: req_if.end_y, end_z: req_if.end_z};

   assign csr_if.ready     = 1'b1;
   assign rsp_if.ray_hit    = rsp_pl.ray_hit;
   assign rsp_if.ray_sum    = rsp_pl.ray_sum;
   assign rsp_if.over_limit = rsp_pl.over_limit;

   vrca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_type  (req_if.req_type),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   vrca_dp #(
      .DIM_MAX     (DIM_MAX),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_pl    (req_pl),
      .csr_we    (csr_if.valid),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .rsp_pl    (rsp_pl)
   );

   // ram writes only on an accepted request
   a_wr_on_transfer: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (req_if.valid && req_if.ready))
      else $error("voxel write without request transfer");

   // result register never overwritten while it still waits
   a_fin_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> (!rsp_if.valid || rsp_if.ready))
      else $error("result overwritten");

   // no sample issued past the clipped length
   a_sample_len: assert property (@(posedge clock) disable iff (reset)
      cmd.sample |-> !stat.len_zero)
      else $error("sample with zero length");

   // a new request is never taken while a result is being loaded
   a_load_fin_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.fin))
      else $error("load and finish together");

endmodule
